### src/bcc_pkg.sv
// shared types, constants and step tables for the balance robot cascade controller
package bcc_pkg;

	localparam int PwmLimitDef      = 6900;
	localparam int IntegralLimitDef = 10000;
	localparam int TiltFaultLimit   = 4000;
	localparam int DistFollowNear   = 200;
	localparam int DistFollowFar    = 500;
	localparam int DistAvoid        = 450;
	localparam int CfgIdxW          = 3;
	localparam int CfgDataW         = 16;

	localparam logic [CfgIdxW-1:0] REG_MIDDLE_ANGLE  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_BALANCE_KP    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BALANCE_KD    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_VELOCITY_KP   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_VELOCITY_KI   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_TURN_KP       = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_TURN_KD       = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPEED_DIVISOR = 3'd7;

	localparam logic [1:0] MODE_AVOID  = 2'd1;
	localparam logic [1:0] MODE_FOLLOW = 2'd2;
	// unused code, behaves as normal mode
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	typedef struct packed {
		logic signed [15:0] tilt_angle;
		logic signed [15:0] tilt_rate;
		logic signed [15:0] yaw_rate;
		logic signed [15:0] left_count;
		logic signed [15:0] right_count;
		logic [15:0]        obstacle_distance;
		logic               forward_req;
		logic               backward_req;
		logic               left_req;
		logic               right_req;
		logic [1:0]         assist_mode;
		logic               halt;
	} item_t;

	typedef struct packed {
		logic [12:0] left_duty;
		logic        left_forward;
		logic [12:0] right_duty;
		logic        right_forward;
		logic        motors_on;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_ABS,
		ST_DIV,
		ST_DONE
	} state_t;

	// 50*256 / divisor, divisor 0 acts as 1
	function automatic logic [13:0] step50(input logic [4:0] d);
		logic [13:0] r;
		unique case (d)
			5'd0, 5'd1: r = 14'd12800;
			5'd2: r = 14'd6400;  5'd3: r = 14'd4266;  5'd4: r = 14'd3200;
			5'd5: r = 14'd2560;  5'd6: r = 14'd2133;  5'd7: r = 14'd1828;
			5'd8: r = 14'd1600;  5'd9: r = 14'd1422;  5'd10: r = 14'd1280;
			5'd11: r = 14'd1163; 5'd12: r = 14'd1066; 5'd13: r = 14'd984;
			5'd14: r = 14'd914;  5'd15: r = 14'd853;  5'd16: r = 14'd800;
			5'd17: r = 14'd752;  5'd18: r = 14'd711;  5'd19: r = 14'd673;
			5'd20: r = 14'd640;  5'd21: r = 14'd609;  5'd22: r = 14'd581;
			5'd23: r = 14'd556;  5'd24: r = 14'd533;  5'd25: r = 14'd512;
			5'd26: r = 14'd492;  5'd27: r = 14'd474;  5'd28: r = 14'd457;
			5'd29: r = 14'd441;  5'd30: r = 14'd426;  5'd31: r = 14'd412;
			default: r = 14'd12800;
		endcase
		return r;
	endfunction

	// 30*256 / divisor
	function automatic logic [13:0] step30(input logic [4:0] d);
		logic [13:0] r;
		unique case (d)
			5'd0, 5'd1: r = 14'd7680;
			5'd2: r = 14'd3840;  5'd3: r = 14'd2560;  5'd4: r = 14'd1920;
			5'd5: r = 14'd1536;  5'd6: r = 14'd1280;  5'd7: r = 14'd1097;
			5'd8: r = 14'd960;   5'd9: r = 14'd853;   5'd10: r = 14'd768;
			5'd11: r = 14'd698;  5'd12: r = 14'd640;  5'd13: r = 14'd590;
			5'd14: r = 14'd548;  5'd15: r = 14'd512;  5'd16: r = 14'd480;
			5'd17: r = 14'd451;  5'd18: r = 14'd426;  5'd19: r = 14'd404;
			5'd20: r = 14'd384;  5'd21: r = 14'd365;  5'd22: r = 14'd349;
			5'd23: r = 14'd333;  5'd24: r = 14'd320;  5'd25: r = 14'd307;
			5'd26: r = 14'd295;  5'd27: r = 14'd284;  5'd28: r = 14'd274;
			5'd29: r = 14'd264;  5'd30: r = 14'd256;  5'd31: r = 14'd247;
			default: r = 14'd7680;
		endcase
		return r;
	endfunction

	// 54*256 / divisor, turn step
	function automatic logic [13:0] step54(input logic [4:0] d);
		logic [13:0] r;
		unique case (d)
			5'd0, 5'd1: r = 14'd13824;
			5'd2: r = 14'd6912;  5'd3: r = 14'd4608;  5'd4: r = 14'd3456;
			5'd5: r = 14'd2764;  5'd6: r = 14'd2304;  5'd7: r = 14'd1974;
			5'd8: r = 14'd1728;  5'd9: r = 14'd1536;  5'd10: r = 14'd1382;
			5'd11: r = 14'd1256; 5'd12: r = 14'd1152; 5'd13: r = 14'd1063;
			5'd14: r = 14'd987;  5'd15: r = 14'd921;  5'd16: r = 14'd864;
			5'd17: r = 14'd813;  5'd18: r = 14'd768;  5'd19: r = 14'd727;
			5'd20: r = 14'd691;  5'd21: r = 14'd658;  5'd22: r = 14'd628;
			5'd23: r = 14'd601;  5'd24: r = 14'd576;  5'd25: r = 14'd552;
			5'd26: r = 14'd531;  5'd27: r = 14'd512;  5'd28: r = 14'd493;
			5'd29: r = 14'd476;  5'd30: r = 14'd460;  5'd31: r = 14'd445;
			default: r = 14'd13824;
		endcase
		return r;
	endfunction

endpackage

### src/balance_robot_cascade_control.sv
// balance robot cascade controller: balance pd, velocity pi and turn pd per control tick
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  item     | item_valid / item_stall     | item (item_t)
//  result   | result_valid / result_stall | result (result_t)
//  cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// one transaction runs from item accept to result through a prep state, a gain-bit serial
// multiply, a sign state, a bit serial division by 100 and a state that saturates and
// loads the output register.
// a finished result waits in the output register while the next item is taken.
// arst_n clears the configuration registers (the speed divisor resets to 2), both loop states and the handshakes.
module balance_robot_cascade_control
	import bcc_pkg::*;
#(
	parameter int DUTY_LIMIT     = PwmLimitDef,
	parameter int INTEGRAL_LIMIT = IntegralLimitDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_t               item,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int W       = 52;
	localparam int CW      = $clog2(W);
	localparam int IntLim  = INTEGRAL_LIMIT * 256;
	localparam int IW      = $clog2(IntLim + 1) + 1;
	localparam int SUMW    = 36;
	localparam int SW      = W + 3;

	state_t state_q, state_d;

	logic signed [10:0] middle_angle_q;
	logic [15:0] balance_kp_q, balance_kd_q, velocity_kp_q, velocity_ki_q;
	logic [15:0] turn_kp_q, turn_kd_q;
	logic [4:0]  speed_divisor_q;

	item_t item_q;
	logic signed [31:0]   sse_q;
	logic signed [IW-1:0] si_q;
	logic signed [31:0]   e_q;
	logic signed [IW-1:0] integ_q;
	logic signed [14:0]   tt_q;
	logic                 off_q;
	logic [CW-1:0]        cnt_q;
	logic signed [W-1:0]  acc_b_q, acc_v_q, acc_t_q;
	logic [W-1:0]         dvd_b_q, dvd_v_q, dvd_t_q;
	logic [6:0]           rem_b_q, rem_v_q, rem_t_q;
	logic                 neg_b_q, neg_v_q, neg_t_q;
	result_t              res_q;
	logic                 res_valid_q;

	logic out_free;
	assign out_free     = !res_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (item_valid) state_d = ST_PREP;
			ST_PREP: state_d = ST_MUL;
			ST_MUL:  if (cnt_q == '0) state_d = ST_ABS;
			ST_ABS:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == '0) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			middle_angle_q  <= '0;
			balance_kp_q    <= '0;
			balance_kd_q    <= '0;
			velocity_kp_q   <= '0;
			velocity_ki_q   <= '0;
			turn_kp_q       <= '0;
			turn_kd_q       <= '0;
			speed_divisor_q <= 5'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIDDLE_ANGLE:  middle_angle_q  <= cfg_data[10:0];
				REG_BALANCE_KP:    balance_kp_q    <= cfg_data;
				REG_BALANCE_KD:    balance_kd_q    <= cfg_data;
				REG_VELOCITY_KP:   velocity_kp_q   <= cfg_data;
				REG_VELOCITY_KI:   velocity_ki_q   <= cfg_data;
				REG_TURN_KP:       turn_kp_q       <= cfg_data;
				REG_TURN_KD:       turn_kd_q       <= cfg_data;
				REG_SPEED_DIVISOR: speed_divisor_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// prep: filter, drive step, clamped integral
	logic signed [40:0]   prod215;
	logic signed [17:0]   least;
	logic signed [24:0]   least41;
	logic signed [40:0]   e_full;
	logic signed [31:0]   e_new;
	logic signed [14:0]   step, tstep, move;
	logic signed [SUMW-1:0] isum, ilim;
	logic signed [IW-1:0] integ_new;
	logic                 avoid, follow, no_turn, fault;
	always_comb begin
		prod215 = (41'(sse_q) <<< 8) - (41'(sse_q) <<< 5) - (41'(sse_q) <<< 3) - 41'(sse_q);
		least   = -(18'(item_q.left_count) + 18'(item_q.right_count));
		least41 = (25'(least) <<< 5) + (25'(least) <<< 3) + 25'(least);
		e_full  = (prod215 >>> 8) + 41'(least41);
		e_new   = e_full[31:0];
		avoid   = (item_q.assist_mode == MODE_AVOID);
		follow  = (item_q.assist_mode == MODE_FOLLOW);
		no_turn = !item_q.left_req && !item_q.right_req;
		fault   = (item_q.tilt_angle < -16'(TiltFaultLimit))
			|| (item_q.tilt_angle > 16'(TiltFaultLimit));
		step    = (avoid || follow) ? $signed({1'b0, step30(speed_divisor_q)})
			: $signed({1'b0, step50(speed_divisor_q)});
		tstep   = $signed({1'b0, step54(speed_divisor_q)});
		move    = item_q.forward_req ? step : (item_q.backward_req ? -step : 15'sd0);
		if (follow && item_q.obstacle_distance > 16'(DistFollowNear)
			&& item_q.obstacle_distance < 16'(DistFollowFar) && no_turn) move = step;
		if (follow && item_q.obstacle_distance < 16'(DistFollowNear) && no_turn) move = -step;
		if (avoid && item_q.obstacle_distance < 16'(DistAvoid) && no_turn) move = -step;
		isum = SUMW'(si_q) + SUMW'(e_new) + SUMW'(move);
		ilim = SUMW'(IntLim);
		if (isum > ilim) integ_new = IW'(ilim);
		else if (isum < -ilim) integ_new = IW'(-ilim);
		else integ_new = IW'(isum);
	end

	// gain bit terms for the horner multiply
	logic                 bit_bp, bit_bd, bit_vp, bit_vi, bit_tp, bit_td;
	logic signed [16:0]   tilt_err;
	logic signed [W-1:0]  term_b, term_v, term_t;
	logic [15:0]          kd_eff;
	always_comb begin
		kd_eff   = (item_q.forward_req || item_q.backward_req) ? turn_kd_q : 16'd0;
		bit_bp   = balance_kp_q[cnt_q[3:0]];
		bit_bd   = balance_kd_q[cnt_q[3:0]];
		bit_vp   = velocity_kp_q[cnt_q[3:0]];
		bit_vi   = velocity_ki_q[cnt_q[3:0]];
		bit_tp   = turn_kp_q[cnt_q[3:0]];
		bit_td   = kd_eff[cnt_q[3:0]];
		tilt_err = 17'(item_q.tilt_angle) - 17'(middle_angle_q);
		term_b   = (bit_bp ? W'(tilt_err) : '0) + (bit_bd ? W'(item_q.tilt_rate) : '0);
		term_v   = (bit_vp ? -W'(e_q) : '0) + (bit_vi ? -W'(integ_q) : '0);
		term_t   = (bit_tp ? W'(tt_q) : '0) + (bit_td ? (W'(item_q.yaw_rate) <<< 8) : '0);
	end

	// one restoring division step by 100
	function automatic logic [7:0] div_step(input logic [6:0] rem, input logic din);
		logic [7:0] t;
		t = {rem, din};
		if (t >= 8'd100) return {1'b1, 7'(t - 8'd100)};
		return {1'b0, t[6:0]};
	endfunction

	logic [7:0] ds_b, ds_v, ds_t;
	assign ds_b = div_step(rem_b_q, dvd_b_q[W-1]);
	assign ds_v = div_step(rem_v_q, dvd_v_q[W-1]);
	assign ds_t = div_step(rem_t_q, dvd_t_q[W-1]);

	// final sum and saturation
	logic signed [SW-1:0] q_b, q_v, q_t, sum_l, sum_r, sat_l, sat_r, lim_pwm;
	logic [SW-1:0]        mag_l, mag_r;
	result_t              res_d;
	always_comb begin
		q_b     = neg_b_q ? -SW'(dvd_b_q) : SW'(dvd_b_q);
		q_v     = neg_v_q ? -SW'(dvd_v_q) : SW'(dvd_v_q);
		q_t     = neg_t_q ? -SW'(dvd_t_q) : SW'(dvd_t_q);
		sum_l   = q_b + q_v + q_t;
		sum_r   = q_b + q_v - q_t;
		lim_pwm = SW'(DUTY_LIMIT);
		sat_l   = (sum_l > lim_pwm) ? lim_pwm : ((sum_l < -lim_pwm) ? -lim_pwm : sum_l);
		sat_r   = (sum_r > lim_pwm) ? lim_pwm : ((sum_r < -lim_pwm) ? -lim_pwm : sum_r);
		mag_l   = sat_l[SW-1] ? SW'(-sat_l) : SW'(sat_l);
		mag_r   = sat_r[SW-1] ? SW'(-sat_r) : SW'(sat_r);
		res_d   = '0;
		if (!off_q) begin
			res_d.left_duty     = mag_l[12:0];
			res_d.left_forward  = (sat_l > 0);
			res_d.right_duty    = mag_r[12:0];
			res_d.right_forward = (sat_r > 0);
			res_d.motors_on     = 1'b1;
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sse_q <= '0;
			si_q  <= '0;
		end else if (state_q == ST_PREP) begin
			sse_q <= e_new;
			si_q  <= (fault || item_q.halt) ? '0 : integ_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// datapath, payload only
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= item;
			end
			ST_PREP: begin
				e_q     <= e_new;
				integ_q <= integ_new;
				tt_q    <= item_q.left_req ? -tstep : (item_q.right_req ? tstep : 15'sd0);
				off_q   <= fault || item_q.halt;
				acc_b_q <= '0;
				acc_v_q <= '0;
				acc_t_q <= '0;
				cnt_q   <= CW'(15);
			end
			ST_MUL: begin
				acc_b_q <= (acc_b_q <<< 1) + term_b;
				acc_v_q <= (acc_v_q <<< 1) + term_v;
				acc_t_q <= (acc_t_q <<< 1) + term_t;
				cnt_q   <= cnt_q - 1'b1;
			end
			ST_ABS: begin
				// velocity and turn divide by 25600: drop 8 bits, then divide by 100
				neg_b_q <= acc_b_q[W-1];
				neg_v_q <= acc_v_q[W-1];
				neg_t_q <= acc_t_q[W-1];
				dvd_b_q <= acc_b_q[W-1] ? W'(-acc_b_q) : W'(acc_b_q);
				dvd_v_q <= (acc_v_q[W-1] ? W'(-acc_v_q) : W'(acc_v_q)) >> 8;
				dvd_t_q <= (acc_t_q[W-1] ? W'(-acc_t_q) : W'(acc_t_q)) >> 8;
				rem_b_q <= '0;
				rem_v_q <= '0;
				rem_t_q <= '0;
				cnt_q   <= CW'(W - 1);
			end
			ST_DIV: begin
				dvd_b_q <= {dvd_b_q[W-2:0], ds_b[7]};
				dvd_v_q <= {dvd_v_q[W-2:0], ds_v[7]};
				dvd_t_q <= {dvd_t_q[W-2:0], ds_t[7]};
				rem_b_q <= ds_b[6:0];
				rem_v_q <= ds_v[6:0];
				rem_t_q <= ds_t[6:0];
				cnt_q   <= cnt_q - 1'b1;
			end
			ST_DONE: begin
				if (out_free) res_q <= res_d;
			end
			default: ;
		endcase
	end

endmodule

### verif/tb.sv
// testbench for the balance robot cascade controller: directed and random control ticks
`timescale 1ns / 100ps

module tb;
	import bcc_pkg::*;

	localparam int ItemW = $bits(item_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	balance_robot_cascade_control dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// controller copy: gains, loop state
	longint g_mid, g_bkp, g_bkd, g_vkp, g_vki, g_tkp, g_tkd, g_div;
	longint speed_err, speed_int;
	result_t duty_queue[$];
	int errors = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int faults_seen = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;

	function automatic longint clamp(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint floor_div256(longint a);
		longint r;
		r = a % 256;
		if (r < 0) r += 256;
		return (a - r) / 256;
	endfunction

	function automatic result_t predict_duty(item_t t);
		longint tilt, dv, stp, mv, least, e, integ, bal, vel, tstp, tt, kd, trn, ml, mr;
		logic avoid, follow, no_turn, off;
		result_t r;
		tilt = t.tilt_angle;
		dv = (g_div == 0) ? 1 : g_div;
		avoid = t.assist_mode == MODE_AVOID;
		follow = t.assist_mode == MODE_FOLLOW;
		no_turn = !t.left_req && !t.right_req;
		off = (tilt < -TiltFaultLimit) || (tilt > TiltFaultLimit) || t.halt;
		bal = (g_bkp * (tilt - g_mid) + g_bkd * longint'(t.tilt_rate)) / 100;
		stp = ((avoid || follow) ? 30 : 50) * 256 / dv;
		mv = t.forward_req ? stp : (t.backward_req ? -stp : 0);
		if (follow && t.obstacle_distance > DistFollowNear && t.obstacle_distance < DistFollowFar
				&& no_turn) mv = stp;
		if (follow && t.obstacle_distance < DistFollowNear && no_turn) mv = -stp;
		if (avoid && t.obstacle_distance < DistAvoid && no_turn) mv = -stp;
		least = -(longint'(t.left_count) + longint'(t.right_count));
		e = floor_div256(speed_err * 215) + least * 41;
		integ = clamp(speed_int + e + mv, longint'(IntegralLimitDef) * 256);
		vel = (-e * g_vkp - integ * g_vki) / 25600;
		speed_err = longint'(int'(e));
		speed_int = off ? 0 : integ;
		tstp = 54 * 256 / dv;
		tt = t.left_req ? -tstp : (t.right_req ? tstp : 0);
		kd = (t.forward_req || t.backward_req) ? g_tkd : 0;
		trn = (tt * g_tkp + longint'(t.yaw_rate) * kd * 256) / 25600;
		ml = clamp(bal + vel + trn, PwmLimitDef);
		mr = clamp(bal + vel - trn, PwmLimitDef);
		r = '0;
		if (!off) begin
			r.left_duty = 13'((ml < 0) ? -ml : ml);
			r.left_forward = ml > 0;
			r.right_duty = 13'((mr < 0) ? -mr : mr);
			r.right_forward = mr > 0;
			r.motors_on = 1'b1;
		end
		return r;
	endfunction

	// receiver stall pattern and result check
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (duty_queue.size() == 0) begin
					errors++;
					$display("%0t unexpected result %h", $time, result);
				end else begin
					result_t x;
					x = duty_queue.pop_front();
					if (x.left_duty !== result.left_duty)
						$display("%0t left_duty exp %0d got %0d", $time, x.left_duty, result.left_duty);
					if (x.left_forward !== result.left_forward)
						$display("%0t left_forward exp %0b got %0b", $time, x.left_forward,
							result.left_forward);
					if (x.right_duty !== result.right_duty)
						$display("%0t right_duty exp %0d got %0d", $time, x.right_duty,
							result.right_duty);
					if (x.right_forward !== result.right_forward)
						$display("%0t right_forward exp %0b got %0b", $time, x.right_forward,
							result.right_forward);
					if (x.motors_on !== result.motors_on)
						$display("%0t motors_on exp %0b got %0b", $time, x.motors_on, result.motors_on);
					if (x !== result) errors++;
				end
			end
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= $urandom_range(0, 3) == 0;
				2: result_stall <= 1'($urandom_range(0, 1));
				default: result_stall <= $urandom_range(0, 15) != 0;
			endcase
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// valid stays up across consecutive writes; set_gains drops it after the last one
	task automatic write_reg(logic [CfgIdxW-1:0] idx, longint val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MIDDLE_ANGLE: g_mid = longint'($signed(11'(val)));
			REG_BALANCE_KP: g_bkp = val & 16'hffff;
			REG_BALANCE_KD: g_bkd = val & 16'hffff;
			REG_VELOCITY_KP: g_vkp = val & 16'hffff;
			REG_VELOCITY_KI: g_vki = val & 16'hffff;
			REG_TURN_KP: g_tkp = val & 16'hffff;
			REG_TURN_KD: g_tkd = val & 16'hffff;
			default: g_div = val & 5'h1f;
		endcase
	endtask

	task automatic drain;
		// close an open burst so the last tick is not taken twice
		if (burst_left != 0) begin
			item_valid <= 1'b0;
			burst_left = 0;
		end
		while (duty_queue.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_gains(longint mid, longint bkp, longint bkd, longint vkp, longint vki,
			longint tkp, longint tkd, longint dv);
		drain();
		write_reg(REG_MIDDLE_ANGLE, mid);
		write_reg(REG_BALANCE_KP, bkp);
		write_reg(REG_BALANCE_KD, bkd);
		write_reg(REG_VELOCITY_KP, vkp);
		write_reg(REG_VELOCITY_KI, vki);
		write_reg(REG_TURN_KP, tkp);
		write_reg(REG_TURN_KD, tkd);
		write_reg(REG_SPEED_DIVISOR, dv);
		cfg_valid <= 1'b0;
	endtask

	// sender with bursts and gaps; valid stays up across back-to-back ticks
	task automatic send_tick(item_t t);
		if (burst_left == 0) begin
			// valid is already low here
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= t;
		do @(posedge clk); while (item_stall);
		duty_queue.push_back(predict_duty(t));
		if (t.halt || t.tilt_angle > TiltFaultLimit || t.tilt_angle < -TiltFaultLimit) faults_seen++;
		ticks_sent++;
		if (burst_left == 0) item_valid <= 1'b0;
	endtask

	function automatic item_t rand_tick(logic sane);
		item_t t;
		t = ItemW'({$urandom, $urandom, $urandom, $urandom});
		if (sane) begin
			t.tilt_angle = 16'($signed($urandom_range(0, 9000)) - 4500);
			t.left_count = 16'($signed($urandom_range(0, 400)) - 200);
			t.right_count = 16'($signed($urandom_range(0, 400)) - 200);
			t.obstacle_distance = 16'($urandom_range(0, 700));
			t.halt = $urandom_range(0, 15) == 0;
		end else if ($urandom_range(0, 1)) begin
			t.tilt_angle = 16'($signed($urandom_range(0, 36000)) - 18000);
		end
		return t;
	endfunction

	task automatic test_directed;
		item_t t;
		set_gains(1000, 2000, 150, 300, 40, 500, 900, 1);
		t = '0;
		send_tick(t);
		t.tilt_angle = 16'sd4000; send_tick(t);
		t.tilt_angle = 16'sd4001; send_tick(t);
		t.tilt_angle = -16'sd4000; send_tick(t);
		t.tilt_angle = -16'sd4001; send_tick(t);
		t.tilt_angle = 16'sd18000; t.tilt_rate = 16'sh7fff; send_tick(t);
		t.tilt_angle = -16'sd18000; t.tilt_rate = 16'sh8000; send_tick(t);
		t = '0; t.halt = 1'b1; t.tilt_angle = 16'sd100; send_tick(t);
		t = '0; t.tilt_angle = 16'sd3000; t.forward_req = 1'b1; t.backward_req = 1'b1;
		t.left_req = 1'b1; t.right_req = 1'b1; t.yaw_rate = 16'sh7fff; send_tick(t);
		t.forward_req = 1'b0; t.left_req = 1'b0; t.yaw_rate = 16'sh8000; send_tick(t);
		t = '0; t.left_count = 16'sh8000; t.right_count = 16'sh8000; send_tick(t);
		send_tick(t);
		t.left_count = 16'sh7fff; t.right_count = 16'sh7fff; send_tick(t);
		t = '0; t.assist_mode = MODE_FOLLOW; t.obstacle_distance = 16'd300; send_tick(t);
		t.obstacle_distance = 16'd100; send_tick(t);
		t.obstacle_distance = 16'd200; send_tick(t);
		t.obstacle_distance = 16'd500; send_tick(t);
		t = '0; t.assist_mode = MODE_AVOID; t.obstacle_distance = 16'd449; send_tick(t);
		t.obstacle_distance = 16'hffff; send_tick(t);
		t.obstacle_distance = 16'd0; t.left_req = 1'b1; send_tick(t);
		t = '0; t.assist_mode = MODE_SPARE; t.obstacle_distance = 16'd10; t.forward_req = 1'b1;
		send_tick(t);
		t.assist_mode = MODE_SPARE; t.forward_req = 1'b0; send_tick(t);
	endtask

	task automatic test_random_phase(int count);
		repeat (count) send_tick(rand_tick($urandom_range(0, 9) != 0));
	endtask

	task automatic test_gain_sweep;
		set_gains(-1000, 65535, 65535, 65535, 65535, 65535, 65535, 16);
		test_random_phase(120);
		set_gains(0, 0, 0, 0, 0, 0, 0, 0);
		test_random_phase(60);
		set_gains(1023, 3000, 100, 500, 20, 400, 300, 31);
		test_random_phase(120);
		set_gains($urandom_range(0, 2047), $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom_range(0, 31));
		test_random_phase(120);
		set_gains(-500, 2500, 80, 200, 5, 800, 600, 2);
		test_random_phase(210);
	endtask

	initial begin
		g_mid = 0; g_bkp = 0; g_bkd = 0; g_vkp = 0; g_vki = 0; g_tkp = 0; g_tkd = 0; g_div = 2;
		speed_err = 0; speed_int = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_gain_sweep();
		drain();
		$display("sent %0d control ticks (%0d with fault or halt) over six gain sets", ticks_sent,
			faults_seen);
		$display("checked %0d results", results_seen);
		if (errors == 0 && duty_queue.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

### files.f
src/bcc_pkg.sv
src/balance_robot_cascade_control.sv
verif/tb.sv
